// ===== hdl/gcpt_pkg.sv =====
// types, character codes and helpers shared by the g-code position tracker
package gcpt_pkg;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_G,
    KIND_X,
    KIND_Y,
    KIND_Z,
    KIND_OTHER
  } word_kind_t;

  typedef enum logic [2:0] {
    G_IDLE,
    G_NINE,
    G_ABS,
    G_REL,
    G_REJECT
  } g_progress_t;

  typedef enum logic [1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_UNUSED
  } reg_index_t;

  typedef struct packed {
    logic neg;
    logic sign;
    logic digit;
    logic point;
    logic done;
  } num_flags_t;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_Y       = 8'h59;
  localparam logic [7:0] CH_Z       = 8'h5A;

  localparam logic signed [31:0] START_RESET = 32'sd10000;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        r = (r << 3) + (r << 1);
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/gcode_axis_position_tracker.sv =====
// top level of the g-code axis position tracker
//
// in channel: one byte of program text per transaction (in_char_in)
// out channel: one transaction per newline outside a comment (status 0) and
// one when an invalid byte is seen (status 1), carrying the committed X, Y,
// Z positions in thousandths of a unit and the absolute/relative mode
// cfg port: APB-style writes of start_x, start_y, start_z at 0x0, 0x4, 0x8;
// a write loads the axis at once and reads return the stored start value
// a byte is registered on acceptance and processed from the input register;
// its result goes to the result register; one byte per cycle is taken while
// no result stalls; the per-byte path is ten times plus digit (scaled digit
// after the point) and clamp, or a load or saturating add per finished word
// reset loads the start values, absolute mode and clears any halt
// when the receiver stalls, a pending result holds and the byte after it
// waits in the input register; bytes that produce no result keep flowing
// after an invalid byte the block halts and ignores input until reset
module gcode_axis_position_tracker #(
  parameter int FRACTION_DIGITS = 3,
  parameter int POSITION_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic        out_relative_mode,
  output logic        out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gcpt_pkg::*;

  localparam int PW    = POSITION_WIDTH;
  localparam int EXT_W = POSITION_WIDTH + 24;
  localparam int FC_W  = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
  localparam logic [EXT_W-1:0] CAP_EXT   = EXT_W'(1) << (PW - 1);
  localparam logic [EXT_W-1:0] INT_SCALE = EXT_W'(pow10(FRACTION_DIGITS));
  localparam logic signed [63:0] POS_MAX64 = (64'sd1 <<< (PW - 1)) - 64'sd1;
  localparam logic signed [63:0] POS_MIN64 = -POS_MAX64 - 64'sd1;
  localparam logic [FC_W-1:0] FC_LIMIT = FC_W'(FRACTION_DIGITS);

  typedef logic signed [PW-1:0] pos_t;

  // state
  pos_t start_x_r, start_y_r, start_z_r;
  pos_t axis_x_r, axis_y_r, axis_z_r, axis_x_nxt, axis_y_nxt, axis_z_nxt;
  pos_t line_x_r, line_y_r, line_z_r, line_x_nxt, line_y_nxt, line_z_nxt;
  logic rel_r, rel_nxt, line_rel_r, line_rel_nxt;
  logic halted_r, halted_nxt, comment_r, comment_nxt;
  word_kind_t kind_r, kind_nxt;
  g_progress_t gprog_r, gprog_nxt;
  logic [PW-1:0] mag_r, mag_nxt;
  num_flags_t flags_r, flags_nxt;
  logic [FC_W-1:0] fc_r, fc_nxt;

  // input register
  logic       s1_vld_r;
  logic [7:0] s1_char_r;

  // result register
  logic       out_vld_r, out_vld_nxt;
  pos_t       res_x_r, res_y_r, res_z_r, res_x_nxt, res_y_nxt, res_z_nxt;
  logic       res_rel_r, res_rel_nxt, res_status_r, res_status_nxt;

  // byte decode
  logic [7:0] c;
  logic [3:0] dval;
  logic is_upper, is_digit, is_num, is_nl, is_semi, emits, adv;

  assign c        = s1_char_r;
  assign dval     = c[3:0];
  assign is_upper = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_num   = is_digit || (c == CH_POINT) || (c == CH_MINUS);
  assign is_nl    = (c == CH_NEWLINE);
  assign is_semi  = (c == CH_SEMI);
  assign emits    = !halted_r && !comment_r && !is_semi && !is_upper && !is_num;
  assign adv      = s1_vld_r && (!emits || !out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || adv;

  // finished word
  logic is_axis;
  pos_t apply_cur, apply_nxt;
  pos_t fin_x, fin_y, fin_z;
  logic fin_rel;

  assign is_axis = (kind_r == KIND_X) || (kind_r == KIND_Y) || (kind_r == KIND_Z);

  always_comb begin
    case (kind_r)
      KIND_X:  apply_cur = line_x_r;
      KIND_Y:  apply_cur = line_y_r;
      KIND_Z:  apply_cur = line_z_r;
      default: apply_cur = line_x_r;
    endcase
  end

  gcpt_word_apply #(
    .POSITION_WIDTH(PW)
  ) u_apply (
    .mag (mag_r),
    .neg (flags_r.neg),
    .rel (line_rel_r),
    .cur (apply_cur),
    .nxt (apply_nxt)
  );

  always_comb begin
    fin_x   = line_x_r;
    fin_y   = line_y_r;
    fin_z   = line_z_r;
    fin_rel = line_rel_r;
    if (kind_r == KIND_G) begin
      if (gprog_r == G_ABS) begin
        fin_rel = 1'b0;
      end else if (gprog_r == G_REL) begin
        fin_rel = 1'b1;
      end
    end else if (is_axis && flags_r.digit) begin
      case (kind_r)
        KIND_X:  fin_x = apply_nxt;
        KIND_Y:  fin_y = apply_nxt;
        KIND_Z:  fin_z = apply_nxt;
        default: fin_x = line_x_r;
      endcase
    end
  end

  // digit accumulation, magnitude kept already scaled to fraction digits
  logic [EXT_W-1:0] mag_ext, dig_ext, frac_scale, mag_sum;
  logic [PW-1:0]    mag_digit;

  always_comb begin
    mag_ext    = EXT_W'(mag_r);
    dig_ext    = EXT_W'(dval);
    frac_scale = EXT_W'(pow10(FRACTION_DIGITS - 1 - int'(fc_r)));
    if (!flags_r.point) begin
      mag_sum = (mag_ext << 3) + (mag_ext << 1) + dig_ext * INT_SCALE;
    end else begin
      mag_sum = mag_ext + dig_ext * frac_scale;
    end
    mag_digit = (mag_sum > CAP_EXT) ? CAP_EXT[PW-1:0] : mag_sum[PW-1:0];
  end

  // configuration port
  logic             cfg_wr;
  reg_index_t       cfg_idx;
  logic signed [63:0] wr_ext;
  pos_t             wr_pos;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_index_t'(cfg_paddr[3:2]);

  always_comb begin
    wr_ext = 64'(signed'(cfg_pwdata));
    if (wr_ext > POS_MAX64) begin
      wr_pos = PW'(POS_MAX64);
    end else if (wr_ext < POS_MIN64) begin
      wr_pos = PW'(POS_MIN64);
    end else begin
      wr_pos = PW'(wr_ext);
    end
  end

  // per-byte next state
  always_comb begin
    axis_x_nxt     = axis_x_r;
    axis_y_nxt     = axis_y_r;
    axis_z_nxt     = axis_z_r;
    line_x_nxt     = line_x_r;
    line_y_nxt     = line_y_r;
    line_z_nxt     = line_z_r;
    rel_nxt        = rel_r;
    line_rel_nxt   = line_rel_r;
    halted_nxt     = halted_r;
    comment_nxt    = comment_r;
    kind_nxt       = kind_r;
    gprog_nxt      = gprog_r;
    mag_nxt        = mag_r;
    flags_nxt      = flags_r;
    fc_nxt         = fc_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_z_nxt      = res_z_r;
    res_rel_nxt    = res_rel_r;
    res_status_nxt = res_status_r;
    if (adv && !halted_r) begin
      if (comment_r) begin
        if (is_nl) begin
          comment_nxt = 1'b0;
        end
      end else if (is_semi) begin
        comment_nxt = 1'b1;
      end else if (is_upper || is_nl) begin
        line_x_nxt   = fin_x;
        line_y_nxt   = fin_y;
        line_z_nxt   = fin_z;
        line_rel_nxt = fin_rel;
        gprog_nxt    = G_IDLE;
        mag_nxt      = '0;
        flags_nxt    = '0;
        fc_nxt       = '0;
        if (is_nl) begin
          kind_nxt       = KIND_NONE;
          axis_x_nxt     = fin_x;
          axis_y_nxt     = fin_y;
          axis_z_nxt     = fin_z;
          rel_nxt        = fin_rel;
          out_vld_nxt    = 1'b1;
          res_x_nxt      = fin_x;
          res_y_nxt      = fin_y;
          res_z_nxt      = fin_z;
          res_rel_nxt    = fin_rel;
          res_status_nxt = 1'b0;
        end else begin
          case (c)
            CH_G:    kind_nxt = KIND_G;
            CH_X:    kind_nxt = KIND_X;
            CH_Y:    kind_nxt = KIND_Y;
            CH_Z:    kind_nxt = KIND_Z;
            default: kind_nxt = KIND_OTHER;
          endcase
        end
      end else if (is_num) begin
        if (kind_r == KIND_G) begin
          if (gprog_r == G_IDLE && c == CH_NINE) begin
            gprog_nxt = G_NINE;
          end else if (gprog_r == G_NINE && c == CH_ZERO) begin
            gprog_nxt = G_ABS;
          end else if (gprog_r == G_NINE && c == CH_ONE) begin
            gprog_nxt = G_REL;
          end else begin
            gprog_nxt = G_REJECT;
          end
        end else if (is_axis && !flags_r.done) begin
          if (c == CH_MINUS) begin
            if (!flags_r.sign && !flags_r.digit && !flags_r.point) begin
              flags_nxt.sign = 1'b1;
              flags_nxt.neg  = 1'b1;
            end else begin
              flags_nxt.done = 1'b1;
            end
          end else if (c == CH_POINT) begin
            if (flags_r.point) begin
              flags_nxt.done = 1'b1;
            end else begin
              flags_nxt.point = 1'b1;
            end
          end else begin
            flags_nxt.digit = 1'b1;
            if (!flags_r.point) begin
              mag_nxt = mag_digit;
            end else if (fc_r < FC_LIMIT) begin
              mag_nxt = mag_digit;
              fc_nxt  = fc_r + FC_W'(1);
            end
          end
        end
      end else begin
        halted_nxt     = 1'b1;
        kind_nxt       = KIND_NONE;
        gprog_nxt      = G_IDLE;
        mag_nxt        = '0;
        flags_nxt      = '0;
        fc_nxt         = '0;
        line_x_nxt     = axis_x_r;
        line_y_nxt     = axis_y_r;
        line_z_nxt     = axis_z_r;
        line_rel_nxt   = rel_r;
        out_vld_nxt    = 1'b1;
        res_x_nxt      = axis_x_r;
        res_y_nxt      = axis_y_r;
        res_z_nxt      = axis_z_r;
        res_rel_nxt    = rel_r;
        res_status_nxt = 1'b1;
      end
    end
    // a start write loads the axis and its line copy at once
    if (cfg_wr) begin
      case (cfg_idx)
        REG_START_X: begin
          axis_x_nxt = wr_pos;
          line_x_nxt = wr_pos;
        end
        REG_START_Y: begin
          axis_y_nxt = wr_pos;
          line_y_nxt = wr_pos;
        end
        REG_START_Z: begin
          axis_z_nxt = wr_pos;
          line_z_nxt = wr_pos;
        end
        default: begin
        end
      endcase
    end
  end

  function automatic logic [31:0] to32(input pos_t p);
    logic signed [63:0] e;
    e = 64'(p);
    return e[31:0];
  endfunction

  always_comb begin
    case (cfg_idx)
      REG_START_X: cfg_prdata = to32(start_x_r);
      REG_START_Y: cfg_prdata = to32(start_y_r);
      REG_START_Z: cfg_prdata = to32(start_z_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r  <= PW'(START_RESET);
      start_y_r  <= PW'(START_RESET);
      start_z_r  <= PW'(START_RESET);
      axis_x_r   <= PW'(START_RESET);
      axis_y_r   <= PW'(START_RESET);
      axis_z_r   <= PW'(START_RESET);
      line_x_r   <= PW'(START_RESET);
      line_y_r   <= PW'(START_RESET);
      line_z_r   <= PW'(START_RESET);
      rel_r      <= 1'b0;
      line_rel_r <= 1'b0;
      halted_r   <= 1'b0;
      comment_r  <= 1'b0;
      kind_r     <= KIND_NONE;
      gprog_r    <= G_IDLE;
      mag_r      <= '0;
      flags_r    <= '0;
      fc_r       <= '0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      axis_x_r   <= axis_x_nxt;
      axis_y_r   <= axis_y_nxt;
      axis_z_r   <= axis_z_nxt;
      line_x_r   <= line_x_nxt;
      line_y_r   <= line_y_nxt;
      line_z_r   <= line_z_nxt;
      rel_r      <= rel_nxt;
      line_rel_r <= line_rel_nxt;
      halted_r   <= halted_nxt;
      comment_r  <= comment_nxt;
      kind_r     <= kind_nxt;
      gprog_r    <= gprog_nxt;
      mag_r      <= mag_nxt;
      flags_r    <= flags_nxt;
      fc_r       <= fc_nxt;
      out_vld_r  <= out_vld_nxt;
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (cfg_wr) begin
        case (cfg_idx)
          REG_START_X: start_x_r <= wr_pos;
          REG_START_Y: start_y_r <= wr_pos;
          REG_START_Z: start_z_r <= wr_pos;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_in;
    end
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    res_z_r      <= res_z_nxt;
    res_rel_r    <= res_rel_nxt;
    res_status_r <= res_status_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_pos_x         = to32(res_x_r);
  assign out_pos_y         = to32(res_y_r);
  assign out_pos_z         = to32(res_z_r);
  assign out_relative_mode = res_rel_r;
  assign out_status        = res_status_r;

endmodule

// ===== hdl/gcpt_word_apply.sv =====
// applies a finished axis word: sign, clamp and absolute load or saturating add
module gcpt_word_apply #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic [POSITION_WIDTH-1:0]        mag,
  input  logic                             neg,
  input  logic                             rel,
  input  logic signed [POSITION_WIDTH-1:0] cur,
  output logic signed [POSITION_WIDTH-1:0] nxt
);

  localparam logic [POSITION_WIDTH-1:0] CAP = {1'b1, {(POSITION_WIDTH-1){1'b0}}};
  localparam logic signed [POSITION_WIDTH-1:0] POS_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
  localparam logic signed [POSITION_WIDTH-1:0] POS_MIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};

  logic signed [POSITION_WIDTH-1:0] val;
  logic signed [POSITION_WIDTH:0]   sum;

  always_comb begin
    if (neg) begin
      val = signed'(-mag);
    end else if (mag == CAP) begin
      val = POS_MAX;
    end else begin
      val = signed'(mag);
    end
    sum = (POSITION_WIDTH+1)'(cur) + (POSITION_WIDTH+1)'(val);
    if (!rel) begin
      nxt = val;
    end else if (sum[POSITION_WIDTH] != sum[POSITION_WIDTH-1]) begin
      nxt = sum[POSITION_WIDTH] ? POS_MIN : POS_MAX;
    end else begin
      nxt = sum[POSITION_WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/gcpt_checker.sv =====
// port-level checks for the g-code position tracker and their binding
module gcpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pos_x,
  input logic [31:0] out_pos_y,
  input logic [31:0] out_pos_z,
  input logic        out_relative_mode,
  input logic        out_status
);

  logic halt_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_seen_r <= 1'b0;
    end else if (out_valid && out_ready && out_status) begin
      halt_seen_r <= 1'b1;
    end
  end

  // no result shown right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // nothing more once an error transaction has gone out
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halt_seen_r |-> !out_valid)
    else $error("result after halt");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_pos_y) &&
      $stable(out_pos_z) && $stable(out_relative_mode) && $stable(out_status))
    else $error("result changed while stalled");

endmodule

bind gcode_axis_position_tracker gcpt_checker u_gcpt_checker (.*);

// ===== verif/gcpt_position_checker.sv =====
// checker that predicts the position reports of the g-code tracker and compares them
module gcpt_position_checker #(
  parameter int FRACTION_DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_pos_x,
  input  logic [31:0] out_pos_y,
  input  logic [31:0] out_pos_z,
  input  logic        out_relative_mode,
  input  logic        out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatches,
  output int          pending
);
  import gcpt_pkg::*;

  localparam longint     POS_MAX = 64'sh7FFF_FFFF;
  localparam longint     POS_MIN = -POS_MAX - 1;
  localparam logic [63:0] MAG_CAP = 64'h8000_0000;
  localparam logic       STATUS_LINE_DONE = 1'b0;
  localparam logic       STATUS_HALTED    = 1'b1;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        rel;
    logic        status;
  } position_report_t;

  position_report_t expected_positions[$];

  longint      axis_x, axis_y, axis_z;
  longint      line_x, line_y, line_z;
  logic        rel_mode, line_rel, halted, in_comment;
  word_kind_t  kind;
  g_progress_t g_state;
  logic [63:0] magnitude;
  num_flags_t  flags;
  int          frac_seen;

  function automatic logic [63:0] mag_step(input logic [63:0] acc, input logic [3:0] d);
    if (acc > (MAG_CAP - 64'(d)) / 10) return MAG_CAP;
    return acc * 10 + 64'(d);
  endfunction

  function automatic longint next_axis(input longint cur, input longint v, input logic relative);
    longint sum;
    if (!relative) return v;
    sum = cur + v;
    if (sum > POS_MAX) return POS_MAX;
    if (sum < POS_MIN) return POS_MIN;
    return sum;
  endfunction

  task automatic clear_word();
    kind      = KIND_NONE;
    g_state   = G_IDLE;
    magnitude = '0;
    flags     = '0;
    frac_seen = 0;
  endtask

  task automatic close_word();
    logic [63:0] m;
    longint      v;
    if (kind == KIND_G) begin
      if (g_state == G_ABS) line_rel = 1'b0;
      else if (g_state == G_REL) line_rel = 1'b1;
    end else if (kind inside {KIND_X, KIND_Y, KIND_Z} && flags.digit) begin
      m = magnitude;
      for (int k = frac_seen; k < FRACTION_DIGITS; k++) m = mag_step(m, 4'd0);
      if (flags.neg) v = (m >= MAG_CAP) ? POS_MIN : -longint'(m);
      else v = (m > 64'(POS_MAX)) ? POS_MAX : longint'(m);
      case (kind)
        KIND_X: line_x = next_axis(line_x, v, line_rel);
        KIND_Y: line_y = next_axis(line_y, v, line_rel);
        default: line_z = next_axis(line_z, v, line_rel);
      endcase
    end
    clear_word();
  endtask

  task automatic push_report(input logic status);
    position_report_t r;
    r.x      = axis_x[31:0];
    r.y      = axis_y[31:0];
    r.z      = axis_z[31:0];
    r.rel    = rel_mode;
    r.status = status;
    expected_positions.insert(expected_positions.size(), r);
  endtask

  task automatic track_char(input logic [7:0] ch);
    if (halted) return;
    if (in_comment) begin
      if (ch == CH_NEWLINE) in_comment = 1'b0;
      return;
    end
    if (ch == CH_SEMI) begin
      in_comment = 1'b1;
      return;
    end
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      close_word();
      case (ch)
        CH_G: kind = KIND_G;
        CH_X: kind = KIND_X;
        CH_Y: kind = KIND_Y;
        CH_Z: kind = KIND_Z;
        default: kind = KIND_OTHER;
      endcase
      return;
    end
    if ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_POINT || ch == CH_MINUS) begin
      if (kind == KIND_G) begin
        if (g_state == G_IDLE && ch == CH_NINE) g_state = G_NINE;
        else if (g_state == G_NINE && ch == CH_ZERO) g_state = G_ABS;
        else if (g_state == G_NINE && ch == CH_ONE) g_state = G_REL;
        else g_state = G_REJECT;
      end else if (kind inside {KIND_X, KIND_Y, KIND_Z} && !flags.done) begin
        if (ch == CH_MINUS) begin
          if (!(flags.sign || flags.digit || flags.point)) begin
            flags.sign = 1'b1;
            flags.neg  = 1'b1;
          end else begin
            flags.done = 1'b1;
          end
        end else if (ch == CH_POINT) begin
          if (flags.point) flags.done = 1'b1;
          else flags.point = 1'b1;
        end else begin
          flags.digit = 1'b1;
          if (!flags.point) begin
            magnitude = mag_step(magnitude, 4'(ch - CH_ZERO));
          end else if (frac_seen < FRACTION_DIGITS) begin
            magnitude = mag_step(magnitude, 4'(ch - CH_ZERO));
            frac_seen++;
          end
        end
      end
      return;
    end
    if (ch == CH_NEWLINE) begin
      close_word();
      axis_x   = line_x;
      axis_y   = line_y;
      axis_z   = line_z;
      rel_mode = line_rel;
      push_report(STATUS_LINE_DONE);
      return;
    end
    // invalid byte: drop the pending line and stop
    halted = 1'b1;
    clear_word();
    line_x   = axis_x;
    line_y   = axis_y;
    line_z   = axis_z;
    line_rel = rel_mode;
    push_report(STATUS_HALTED);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    position_report_t want;
    if (!rst_n) begin
      axis_x     = START_RESET;
      axis_y     = START_RESET;
      axis_z     = START_RESET;
      line_x     = START_RESET;
      line_y     = START_RESET;
      line_z     = START_RESET;
      rel_mode   = 1'b0;
      line_rel   = 1'b0;
      halted     = 1'b0;
      in_comment = 1'b0;
      clear_word();
      expected_positions.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          report_mismatch("unexpected transaction pos_x", out_pos_x, '0);
        end else begin
          want = expected_positions.pop_front();
          if (out_pos_x !== want.x) report_mismatch("pos_x", out_pos_x, want.x);
          if (out_pos_y !== want.y) report_mismatch("pos_y", out_pos_y, want.y);
          if (out_pos_z !== want.z) report_mismatch("pos_z", out_pos_z, want.z);
          if (out_relative_mode !== want.rel)
            report_mismatch("relative_mode", 32'(out_relative_mode), 32'(want.rel));
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_index_t'(cfg_paddr[3:2]))
          REG_START_X: begin
            axis_x = longint'($signed(cfg_pwdata));
            line_x = axis_x;
          end
          REG_START_Y: begin
            axis_y = longint'($signed(cfg_pwdata));
            line_y = axis_y;
          end
          REG_START_Z: begin
            axis_z = longint'($signed(cfg_pwdata));
            line_z = axis_z;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) track_char(in_char_in);
    end
    pending = expected_positions.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// top of the g-code position tracker testbench: clock, reset, stimulus and verdict
module tb_top;
  import gcpt_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic        out_relative_mode, out_status;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int   mismatches, pending;
  int   program_chars = 0;
  int   quiet_cycles = 0;
  logic gaps_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gcode_axis_position_tracker dut (.*);

  gcpt_position_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_char_in,
    .out_valid, .out_ready, .out_pos_x, .out_pos_y, .out_pos_z,
    .out_relative_mode, .out_status,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .mismatches, .pending
  );

  // receiver back-pressure
  always @(negedge clk) begin
    if (gaps_on) out_ready <= ($urandom_range(99) >= 22);
    else out_ready <= 1'b1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_char(input logic [7:0] ch);
    while (gaps_on && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    program_chars++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start(input reg_index_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_starts(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    write_start(REG_START_X, x);
    write_start(REG_START_Y, y);
    write_start(REG_START_Z, z);
  endtask

  task automatic send_digits(input int count);
    repeat (count) send_char(8'(CH_ZERO + $urandom_range(9)));
  endtask

  task automatic send_number();
    if ($urandom_range(2) == 0) send_char(CH_MINUS);
    send_digits(($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3));
    if ($urandom_range(1)) begin
      send_char(CH_POINT);
      send_digits($urandom_range(5));
    end
    // broken number: stray sign or point, then up to two more digits
    if ($urandom_range(9) == 0) begin
      send_char($urandom_range(1) ? CH_MINUS : CH_POINT);
      send_digits($urandom_range(2));
    end
  endtask

  task automatic send_comment();
    logic [7:0] b;
    send_char(CH_SEMI);
    repeat ($urandom_range(4)) begin
      b = 8'($urandom_range(255));
      if (b == CH_NEWLINE) b = 8'hFF;
      send_char(b);
    end
    send_char(CH_NEWLINE);
  endtask

  task automatic send_random_line();
    logic [7:0] noise [3] = '{CH_ZERO, CH_POINT, CH_MINUS};
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 3)) send_char(noise[$urandom_range(2)]);
      send_digits($urandom_range(1));
    end
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(10))
        0, 1: begin
          send_char(CH_G);
          send_char(CH_NINE);
          send_char($urandom_range(1) ? CH_ONE : CH_ZERO);
        end
        2: begin
          send_char(CH_G);
          repeat ($urandom_range(3)) send_char(($urandom_range(3) == 0) ?
                                               noise[$urandom_range(2)] :
                                               8'(CH_ZERO + $urandom_range(9)));
        end
        3, 4: begin
          send_char(CH_X);
          send_number();
        end
        5, 6: begin
          send_char(CH_Y);
          send_number();
        end
        7, 8: begin
          send_char(CH_Z);
          send_number();
        end
        9: begin
          send_char(8'(CH_UPPER_A + $urandom_range(25)));
          send_number();
        end
        default: send_comment();
      endcase
    end
    send_char(CH_NEWLINE);
  endtask

  initial begin
    logic [7:0] bad;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_starts(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);

    // leading digit, comment holding byte extremes, relative move, saturation,
    // word with no digits, absolute mode and an ignored letter
    send_text("7;");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_NEWLINE);
    send_text("G91Z-.5\n");
    send_text("X9999999999Y\n");
    send_text("G90A\n");
    send_text("X-1.23456\n");
    wait_for_results();

    load_starts($urandom(), $urandom(), $urandom());
    program_chars = 0;
    while (program_chars < 300) begin
      gaps_on = !(program_chars > 100 && program_chars < 250);
      send_random_line();
    end
    gaps_on = 1'b1;
    wait_for_results();

    load_starts(32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(20000));
    program_chars = 0;
    while (program_chars < 300) send_random_line();

    // invalid byte mid-line, then bytes that a halted tracker ignores
    send_text("X5");
    bad = $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'h20;
    send_char(bad);
    send_text("X1\nG91\n");
    wait_for_results();
    repeat (20) @(posedge clk);

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
